// ===== design/rau_pkg.sv =====
// shared types and codes for the rational arithmetic unit
`default_nettype none
package rau_pkg;

  // operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_INV   = 3'd4;
  localparam logic [2:0] OP_SCALE = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // request from the sequencer to the shift unit
  typedef struct packed {
    logic start;
    logic div_mode;
  } rau_req_t;

endpackage
`default_nettype wire

// ===== design/rau_shunit.sv =====
// bit-serial unsigned multiply / restoring divide unit, one bit per cycle
`default_nettype none
module rau_shunit #(
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rau_pkg::rau_req_t         req,
  input  wire logic [WORD_WIDTH-1:0]     opx,
  input  wire logic [WORD_WIDTH-1:0]     opy,
  output logic                           done,
  output logic [2*WORD_WIDTH-1:0]        result
);

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W);

  logic [2*W-1:0] p_r;
  logic [W-1:0]   y_r;
  logic           mode_r;
  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;

  logic [W:0]     msum;
  logic [W:0]     rsh;
  logic [W:0]     rdiff;
  logic           ge;

  // one step of either operation
  always_comb begin
    msum  = {1'b0, p_r[2*W-1:W]} + (p_r[0] ? {1'b0, y_r} : {(W+1){1'b0}});
    rsh   = {p_r[2*W-1:W], p_r[W-1]};
    rdiff = rsh - {1'b0, y_r};
    ge    = (rsh >= {1'b0, y_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
        mode_r <= req.div_mode;
        y_r    <= opy;
        p_r    <= {{W{1'b0}}, opx};
      end else if (busy_r) begin
        if (mode_r) begin
          p_r <= {(ge ? rdiff[W-1:0] : rsh[W-1:0]), p_r[W-2:0], ge};
        end else begin
          p_r <= {msum, p_r[W-1:1]};
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = p_r;

endmodule
`default_nettype wire

// ===== design/rational_arithmetic_unit.sv =====
// top level: sequencer around the shared shift unit
// Each transaction takes one item at a time. Invert and pass-through codes go from idle
// straight to the finish state. Every run of the shared unit has a start step,
// WORD_WIDTH bit steps and a registered done. Multiply, divide and scale
// run two (scale one) serial products. Add and subtract run Euclid's gcd on the absolute
// denominators (one serial division per remainder step, plus a check that sees the zero
// remainder), two more divisions for the lcm factors and three products; all of these
// runs use the single bit-serial multiply/divide unit. in_ready is high only while the
// sequencer is idle; a finished result waits in the output register.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int WORD_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_operation,
  input  wire logic signed [31:0] in_a_numerator,
  input  wire logic signed [31:0] in_a_denominator,
  input  wire logic signed [31:0] in_b_numerator,
  input  wire logic signed [31:0] in_b_denominator,
  input  wire logic signed [31:0] in_scale_factor,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_result_numerator,
  output logic signed [31:0]      out_result_denominator,
  output logic [1:0]              out_status
);

  localparam int W = WORD_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE, S_GCD, S_DIVKA, S_DIVKB, S_MUL0, S_MUL1, S_MUL2, S_FIN
  } state_t;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  state_t            state_r;
  logic              pend_r;
  logic [2:0]        op_r;
  logic [W-1:0]      an_r, ad_r, bn_r, bd_r, sf_r;
  logic [W-1:0]      x_r, y_r, ka_r, kb_r, t1_r, rn_r, rd_r;
  logic              ovf_r, zden_r;
  logic              out_valid_r;
  logic [31:0]       orn_r, ord_r;
  logic [1:0]        ost_r;

  logic [W-1:0]      i_an, i_ad, i_bn, i_bd;
  rau_pkg::rau_req_t req;
  logic [W-1:0]      opx, opy;
  logic              mneg;
  logic              u_done;
  logic [2*W-1:0]    u_res;
  logic [W-1:0]      mres, msum;
  logic              movf, sovf;
  logic              is_addsub;

  assign i_an = W'(in_a_numerator);
  assign i_ad = W'(in_a_denominator);
  assign i_bn = W'(in_b_numerator);
  assign i_bd = W'(in_b_denominator);
  assign is_addsub = (op_r == rau_pkg::OP_ADD) || (op_r == rau_pkg::OP_SUB);

  // operand selection for the shared unit
  always_comb begin
    // start a unit run once per entry into a work state and once per gcd remainder step, except a finished gcd
    req.start = pend_r && (state_r != S_IDLE) && (state_r != S_FIN) &&
                !((state_r == S_GCD) && (y_r == '0));
    opx  = '0;
    opy  = '0;
    mneg = 1'b0;
    req.div_mode = 1'b0;
    case (state_r)
      S_GCD: begin
        opx = x_r; opy = y_r; req.div_mode = 1'b1;
      end
      S_DIVKA: begin
        opx = mag(bd_r); opy = x_r; req.div_mode = 1'b1;
      end
      S_DIVKB: begin
        opx = mag(ad_r); opy = x_r; req.div_mode = 1'b1;
      end
      S_MUL0: begin
        if (is_addsub) begin
          opx = ka_r; opy = mag(ad_r);
        end else if (op_r == rau_pkg::OP_MUL) begin
          opx = mag(an_r); opy = mag(bn_r); mneg = an_r[W-1] ^ bn_r[W-1];
        end else if (op_r == rau_pkg::OP_DIV) begin
          opx = mag(an_r); opy = mag(bd_r); mneg = an_r[W-1] ^ bd_r[W-1];
        end else begin
          opx = mag(an_r); opy = mag(sf_r); mneg = an_r[W-1] ^ sf_r[W-1];
        end
      end
      S_MUL1: begin
        if (is_addsub) begin
          opx = mag(an_r); opy = ka_r; mneg = an_r[W-1] ^ ad_r[W-1];
        end else if (op_r == rau_pkg::OP_MUL) begin
          opx = mag(ad_r); opy = mag(bd_r); mneg = ad_r[W-1] ^ bd_r[W-1];
        end else begin
          opx = mag(ad_r); opy = mag(bn_r); mneg = ad_r[W-1] ^ bn_r[W-1];
        end
      end
      S_MUL2: begin
        opx = mag(bn_r); opy = kb_r; mneg = bn_r[W-1] ^ bd_r[W-1];
      end
      default: begin
        opx = '0;
      end
    endcase
  end

  rau_shunit #(.WORD_WIDTH(W)) u_shunit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opx    (opx),
    .opy    (opy),
    .done   (u_done),
    .result (u_res)
  );

  // signed wrap and overflow of a product, and of the final sum
  always_comb begin
    mres = mneg ? (~u_res[W-1:0] + 1'b1) : u_res[W-1:0];
    movf = (u_res[2*W-1:W] != '0) ||
           (u_res[W-1] && !(mneg && (u_res[W-2:0] == '0)));
    msum = t1_r + mres;
    sovf = (t1_r[W-1] == mres[W-1]) && (msum[W-1] != t1_r[W-1]);
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (req.start) begin
        pend_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= in_operation;
            an_r   <= i_an;
            ad_r   <= i_ad;
            bd_r   <= i_bd;
            sf_r   <= W'(in_scale_factor);
            zden_r <= 1'b0;
            pend_r <= 1'b1;
            if (in_operation == rau_pkg::OP_SUB) begin
              bn_r  <= ~i_bn + 1'b1;
              ovf_r <= (i_bn == {1'b1, {(W-1){1'b0}}});
            end else begin
              bn_r  <= i_bn;
              ovf_r <= 1'b0;
            end
            x_r <= mag(i_ad);
            y_r <= mag(i_bd);
            rn_r <= i_an;
            rd_r <= i_ad;
            case (in_operation)
              rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                if ((i_ad == '0) || (i_bd == '0)) begin
                  rn_r   <= '0;
                  rd_r   <= '0;
                  zden_r <= 1'b1;
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_GCD;
                end
              end
              rau_pkg::OP_MUL, rau_pkg::OP_DIV, rau_pkg::OP_SCALE: begin
                state_r <= S_MUL0;
              end
              rau_pkg::OP_INV: begin
                rn_r    <= i_ad;
                rd_r    <= i_an;
                state_r <= S_FIN;
              end
              default: begin
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_GCD: begin
          if (pend_r && (y_r == '0)) begin
            state_r <= S_DIVKA;
          end else if (u_done) begin
            x_r    <= y_r;
            y_r    <= u_res[2*W-1:W];
            pend_r <= 1'b1;
          end
        end
        S_DIVKA: begin
          if (u_done) begin
            ka_r    <= u_res[W-1:0];
            pend_r  <= 1'b1;
            state_r <= S_DIVKB;
          end
        end
        S_DIVKB: begin
          if (u_done) begin
            kb_r    <= u_res[W-1:0];
            pend_r  <= 1'b1;
            state_r <= S_MUL0;
          end
        end
        S_MUL0: begin
          if (u_done) begin
            ovf_r  <= ovf_r | movf;
            pend_r <= 1'b1;
            if (is_addsub) begin
              rd_r    <= mres;
              state_r <= S_MUL1;
            end else if (op_r == rau_pkg::OP_SCALE) begin
              rn_r    <= mres;
              state_r <= S_FIN;
            end else begin
              rn_r    <= mres;
              state_r <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          if (u_done) begin
            ovf_r  <= ovf_r | movf;
            pend_r <= 1'b1;
            if (is_addsub) begin
              t1_r    <= mres;
              state_r <= S_MUL2;
            end else begin
              rd_r    <= mres;
              state_r <= S_FIN;
            end
          end
        end
        S_MUL2: begin
          if (u_done) begin
            ovf_r   <= ovf_r | movf | sovf;
            rn_r    <= msum;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            orn_r <= 32'($signed(rn_r));
            ord_r <= 32'($signed(rd_r));
            ost_r <= zden_r ? rau_pkg::ST_ZDEN :
                     (ovf_r ? rau_pkg::ST_OVF : rau_pkg::ST_OK);
            pend_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready               = (state_r == S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_result_numerator   = orn_r;
  assign out_result_denominator = ord_r;
  assign out_status             = ost_r;

endmodule
`default_nettype wire
